// ----- rtl/core/row_top_k_index_select_macros.svh -----
// Assertion macros for the row top-k index selector.
// Used at the end of the top level; needs i_clk and i_rst_n in scope.
`ifndef ROW_TOP_K_INDEX_SELECT_MACROS_SVH
`define ROW_TOP_K_INDEX_SELECT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define RTK_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define RTK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/rtk_pkg.sv -----
// Shared types and constants for the row top-k index selector.
// Used by rtk_cell and row_top_k_index_select; no dependencies.
package rtk_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] REG_K_USED          = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SMALLEST_FIRST  = 1'b1;

    // Control phase of the block
    typedef enum logic {
        PH_COLLECT,
        PH_EMIT
    } t_phase;

    // Handed from one cell to the next
    typedef struct packed {
        logic pass;   // this cell and all before it rank at least as well
        logic valid;  // this cell holds an entry
    } t_cell_ctl;

    // Broadcast from the top level to every cell
    typedef struct packed {
        logic load;      // an element transfer happens this cycle
        logic drain;     // a result transfer happens this cycle
        logic smallest;  // smallest values rank best
    } t_cell_cmd;

endpackage

// ----- rtl/core/rtk_cell.sv -----
// One slot of the ranked list: holds a value, its column and a valid bit.
// Depends on rtk_pkg. Cells are chained; cell 0 holds the best entry.
module rtk_cell #(
    parameter int unsigned VALUE_BITS = 32,
    parameter int unsigned COL_BITS   = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rtk_pkg::t_cell_cmd    i_cmd,
    input  logic                  i_active,
    input  logic [VALUE_BITS-1:0] i_new_value,
    input  logic [VALUE_BITS-1:0] i_new_key,
    input  logic [COL_BITS-1:0]   i_new_column,
    input  rtk_pkg::t_cell_ctl    i_prev_ctl,
    input  logic [VALUE_BITS-1:0] i_prev_value,
    input  logic [COL_BITS-1:0]   i_prev_column,
    input  logic                  i_next_valid,
    input  logic [VALUE_BITS-1:0] i_next_value,
    input  logic [COL_BITS-1:0]   i_next_column,
    output rtk_pkg::t_cell_ctl    o_ctl,
    output logic [VALUE_BITS-1:0] o_value,
    output logic [COL_BITS-1:0]   o_column
);

    localparam logic [VALUE_BITS-1:0] SIGN_BIT = {1'b1, {(VALUE_BITS-1){1'b0}}};

    logic                  r_valid;
    logic [VALUE_BITS-1:0] r_value;
    logic [COL_BITS-1:0]   r_column;
    logic [VALUE_BITS-1:0] w_key;
    logic                  w_stay;

    // Order key of the held value under the current mode
    assign w_key  = r_value ^ SIGN_BIT ^ {VALUE_BITS{i_cmd.smallest}};
    // Held entry ties or beats the incoming one: it stays ahead
    assign w_stay = r_valid & i_active & (w_key >= i_new_key);

    assign o_ctl.pass  = i_prev_ctl.pass & w_stay;
    assign o_ctl.valid = r_valid;
    assign o_value     = r_value;
    assign o_column    = r_column;

    // Valid bit: insert, shift down, drop beyond k, or shift up while draining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.load) begin
            if (!i_active) begin
                r_valid <= 1'b0;
            end else if (i_prev_ctl.pass) begin
                if (!w_stay) begin
                    r_valid <= 1'b1;
                end
            end else begin
                r_valid <= i_prev_ctl.valid;
            end
        end else if (i_cmd.drain) begin
            r_valid <= i_next_valid;
        end
    end

    // Payload follows the same moves
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (i_prev_ctl.pass) begin
                if (!w_stay) begin
                    r_value  <= i_new_value;
                    r_column <= i_new_column;
                end
            end else begin
                r_value  <= i_prev_value;
                r_column <= i_prev_column;
            end
        end else if (i_cmd.drain) begin
            r_value  <= i_next_value;
            r_column <= i_next_column;
        end
    end

endmodule

// ----- rtl/core/row_top_k_index_select.sv -----
// Row top-k index selector: streams one row element per transfer and keeps
// the best k of the row in a chain of insertion cells.
// Depends on rtk_pkg, rtk_cell and row_top_k_index_select_macros.svh.
//
// Input channel (i_in_valid / o_in_stall): one signed element per transfer,
// numbered by column from 0 within its row; i_row_end marks the last one.
// Within a row the block takes one element per cycle: every cell compares its
// entry against the new one in parallel and the insertion point is found along
// the cell chain.
// The cycle after the row's last element the block starts to emit the kept
// column indices, best first, one per cycle (o_out_valid / i_out_stall);
// o_rank counts from 0 and o_final_result marks the last one. The list is
// drained out of cell 0; a row keeps n <= k entries, and o_in_stall is high
// until the last of them has left.
// When the receiver stalls, the current result holds and the drain pauses.
// Configuration (i_cfg_valid / o_cfg_ready) is always ready; register 0 is
// k_used, register 1 is smallest_first. Write only while the block is idle.
// Reset clears the list, the column count and sets k_used to MAX_K and
// largest-first order.
module row_top_k_index_select #(
    parameter int unsigned MAX_K       = 16,
    parameter int unsigned MAX_COLUMNS = 65536,
    parameter int unsigned VALUE_BITS  = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // element input
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [VALUE_BITS-1:0]        i_sample_value,
    input  logic                                i_row_end,
    // result output
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [$clog2(MAX_COLUMNS)-1:0]      o_column_index,
    output logic [$clog2(MAX_K)-1:0]            o_rank,
    output logic                                o_final_result,
    // configuration
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rtk_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [$clog2(MAX_K+1)-1:0]          i_cfg_data
);

    localparam int unsigned COL_BITS  = $clog2(MAX_COLUMNS);
    localparam int unsigned RANK_BITS = $clog2(MAX_K);
    localparam int unsigned K_BITS    = $clog2(MAX_K + 1);
    localparam logic [COL_BITS-1:0]   COL_LAST = COL_BITS'(MAX_COLUMNS - 1);
    localparam logic [K_BITS-1:0]     K_MAX    = K_BITS'(MAX_K);
    localparam logic [K_BITS-1:0]     K_ONE    = K_BITS'(1);
    localparam logic [VALUE_BITS-1:0] SIGN_BIT = {1'b1, {(VALUE_BITS-1){1'b0}}};

    rtk_pkg::t_phase       r_phase, n_phase;
    logic [K_BITS-1:0]     r_k_used;
    logic                  r_smallest;
    logic [COL_BITS-1:0]   r_col_cnt;
    logic [RANK_BITS-1:0]  r_rank;

    logic                  w_in_xfer;
    logic                  w_out_xfer;
    logic                  w_final;
    logic                  w_emit;
    logic                  w_row_done;
    logic                  w_row_last;
    logic [K_BITS-1:0]     w_k_eff;
    logic [VALUE_BITS-1:0] w_new_key;
    rtk_pkg::t_cell_cmd    w_cmd;

    rtk_pkg::t_cell_ctl    w_ctl [MAX_K];
    logic [VALUE_BITS-1:0] w_val [MAX_K];
    logic [COL_BITS-1:0]   w_col [MAX_K];

    // Handshakes
    assign o_in_stall  = (r_phase == rtk_pkg::PH_EMIT);
    assign o_out_valid = (r_phase == rtk_pkg::PH_EMIT);
    assign o_cfg_ready = 1'b1;
    assign w_in_xfer   = i_in_valid & ~o_in_stall;
    assign w_out_xfer  = o_out_valid & ~i_out_stall;

    // Results come from the head of the chain
    assign w_final         = ~w_ctl[1].valid;
    assign o_column_index  = w_col[0];
    assign o_rank          = r_rank;
    assign o_final_result  = w_final;

    // Effective k: zero acts as one, above MAX_K acts as MAX_K
    always_comb begin
        if (r_k_used == '0) begin
            w_k_eff = K_ONE;
        end else if (r_k_used > K_MAX) begin
            w_k_eff = K_MAX;
        end else begin
            w_k_eff = r_k_used;
        end
    end

    // Order key of the incoming element
    assign w_new_key = VALUE_BITS'(i_sample_value) ^ SIGN_BIT ^ {VALUE_BITS{r_smallest}};

    assign w_cmd.load     = w_in_xfer;
    assign w_cmd.drain    = w_out_xfer;
    assign w_cmd.smallest = r_smallest;

    // Cell chain
    for (genvar g = 0; g < MAX_K; g++) begin : g_cell
        rtk_pkg::t_cell_ctl    w_prev_ctl;
        logic [VALUE_BITS-1:0] w_prev_val;
        logic [COL_BITS-1:0]   w_prev_col;
        logic                  w_next_vld;
        logic [VALUE_BITS-1:0] w_next_val;
        logic [COL_BITS-1:0]   w_next_col;

        if (g == 0) begin : g_head
            assign w_prev_ctl.pass  = 1'b1;
            assign w_prev_ctl.valid = 1'b0;
            assign w_prev_val       = '0;
            assign w_prev_col       = '0;
        end else begin : g_body
            assign w_prev_ctl = w_ctl[g-1];
            assign w_prev_val = w_val[g-1];
            assign w_prev_col = w_col[g-1];
        end

        if (g == MAX_K - 1) begin : g_tail
            assign w_next_vld = 1'b0;
            assign w_next_val = '0;
            assign w_next_col = '0;
        end else begin : g_more
            assign w_next_vld = w_ctl[g+1].valid;
            assign w_next_val = w_val[g+1];
            assign w_next_col = w_col[g+1];
        end

        rtk_cell #(
            .VALUE_BITS (VALUE_BITS),
            .COL_BITS   (COL_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_active      (K_BITS'(g) < w_k_eff),
            .i_new_value   (VALUE_BITS'(i_sample_value)),
            .i_new_key     (w_new_key),
            .i_new_column  (r_col_cnt),
            .i_prev_ctl    (w_prev_ctl),
            .i_prev_value  (w_prev_val),
            .i_prev_column (w_prev_col),
            .i_next_valid  (w_next_vld),
            .i_next_value  (w_next_val),
            .i_next_column (w_next_col),
            .o_ctl         (w_ctl[g]),
            .o_value       (w_val[g]),
            .o_column      (w_col[g])
        );
    end

    // Phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rtk_pkg::PH_COLLECT;
        end else begin
            r_phase <= n_phase;
        end
    end

    // Next phase: emit after the row's last element, back when the last leaves
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            rtk_pkg::PH_COLLECT: begin
                if (w_in_xfer && i_row_end) begin
                    n_phase = rtk_pkg::PH_EMIT;
                end
            end
            rtk_pkg::PH_EMIT: begin
                if (w_out_xfer && w_final) begin
                    n_phase = rtk_pkg::PH_COLLECT;
                end
            end
            default: n_phase = rtk_pkg::PH_COLLECT;
        endcase
    end

    // Column counter, saturating; restarts at each row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
        end else if (w_in_xfer) begin
            if (i_row_end) begin
                r_col_cnt <= '0;
            end else if (r_col_cnt != COL_LAST) begin
                r_col_cnt <= r_col_cnt + COL_BITS'(1);
            end
        end
    end

    // Rank of the result on the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= '0;
        end else if (w_in_xfer) begin
            r_rank <= '0;
        end else if (w_out_xfer) begin
            r_rank <= r_rank + RANK_BITS'(1);
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_used   <= K_MAX;
            r_smallest <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                rtk_pkg::REG_K_USED:         r_k_used   <= i_cfg_data;
                rtk_pkg::REG_SMALLEST_FIRST: r_smallest <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Checks
    assign w_emit     = (r_phase == rtk_pkg::PH_EMIT);
    assign w_row_done = w_in_xfer && i_row_end;
    assign w_row_last = w_out_xfer && w_final;

    `include "row_top_k_index_select_macros.svh"

    `RTK_ASSERT_IMPL(a_emit_head_valid, w_emit, w_ctl[0].valid, "emitting from an empty list")
    `RTK_ASSERT_NEXT(a_row_end_emit, w_row_done, w_emit && (r_rank == '0), "bad emission start")
    `RTK_ASSERT_NEXT(a_drained, w_row_last, !w_ctl[0].valid && r_col_cnt == '0, "list not empty")

endmodule

// ----- dv/row_top_k_index_select_tb.sv -----
// Self-checking testbench for row_top_k_index_select: drives rows of signed elements,
// tracks the best-k selection per row in a local model and checks every emitted index.
// Depends on rtk_pkg and the row_top_k_index_select RTL.
module row_top_k_index_select_tb;

    localparam int KEEP_MAX  = 16;
    localparam int COL_LAST  = 65535;
    localparam int SETTLE    = 8;
    localparam int ERR_SHOWN = 10;

    // One emitted selection entry
    typedef struct packed {
        logic [15:0] column;
        logic [3:0]  rank;
        logic        last;
    } t_pick;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic signed [31:0] i_sample_value = '0;
    logic               i_row_end      = 1'b0;
    logic               i_out_stall    = 1'b0;
    logic               i_cfg_valid    = 1'b0;
    logic [rtk_pkg::CFG_IDX_BITS-1:0] i_cfg_index = rtk_pkg::REG_K_USED;
    logic [4:0]         i_cfg_data     = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [15:0]        o_column_index;
    logic [3:0]         o_rank;
    logic               o_final_result;
    logic               o_cfg_ready;

    // Selection model state
    logic [4:0]         sel_k       = 5'd16;
    logic               sel_smallest = 1'b0;
    logic signed [31:0] kept_val [KEEP_MAX];
    logic [15:0]        kept_col [KEEP_MAX];
    int                 kept_n   = 0;
    int                 col_next = 0;
    t_pick              pending_picks[$];

    int fail_count  = 0;
    int long_hold   = 0;
    int stall_burst = 0;
    bit idle_on     = 1'b1;

    row_top_k_index_select u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample_value (i_sample_value),
        .i_row_end      (i_row_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_column_index (o_column_index),
        .o_rank         (o_rank),
        .o_final_result (o_final_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Larger key ranks better under the current order
    function automatic logic [31:0] rank_key(logic [31:0] v);
        logic [31:0] key;
        key = {~v[31], v[30:0]};
        if (sel_smallest) key = ~key;
        return key;
    endfunction

    // Insert one element into the kept list; on row end queue the picks
    task automatic select_update(logic signed [31:0] value, logic last);
        int limit;
        int pos;
        int top;
        logic [31:0] key;
        limit = (sel_k == 0) ? 1 : (sel_k > KEEP_MAX) ? KEEP_MAX : int'(sel_k);
        key = rank_key(value);
        if (kept_n > limit) kept_n = limit;
        pos = 0;
        while (pos < kept_n && rank_key(kept_val[pos]) >= key) pos++;
        if (pos < limit) begin
            top = (kept_n < limit) ? kept_n : limit - 1;
            for (int i = top; i > pos; i--) begin
                kept_val[i] = kept_val[i-1];
                kept_col[i] = kept_col[i-1];
            end
            kept_val[pos] = value;
            kept_col[pos] = col_next[15:0];
            if (kept_n < limit) kept_n++;
        end
        if (col_next < COL_LAST) col_next++;
        if (last) begin
            for (int i = 0; i < kept_n; i++)
                pending_picks.push_back('{kept_col[i], i[3:0], (i + 1 == kept_n)});
            kept_n = 0;
            col_next = 0;
        end
    endtask

    // Receiver: random stall bursts plus an optional long hold-off
    always @(negedge i_clk) begin : drive_out_stall
        logic stall_next;
        if (long_hold > 0) begin
            stall_next = 1'b1;
            long_hold--;
        end else if (stall_burst > 0) begin
            stall_next = 1'b1;
            stall_burst--;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_burst = $urandom_range(0, 11);
            stall_next = 1'b1;
        end else begin
            stall_next = 1'b0;
        end
        i_out_stall <= stall_next;
    end

    // Compare each result transfer with the oldest expected pick
    always @(posedge i_clk) begin : check_results
        t_pick want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_picks.size() == 0) begin
                fail_count++;
                if (fail_count <= ERR_SHOWN)
                    $display("unexpected result: column %0d rank %0d final %0b",
                             o_column_index, o_rank, o_final_result);
            end else begin
                want = pending_picks.pop_front();
                if (o_column_index !== want.column || o_rank !== want.rank ||
                    o_final_result !== want.last) begin
                    fail_count++;
                    if (fail_count <= ERR_SHOWN)
                        $display("result differs: exp col %0d rank %0d final %0b,",
                                 want.column, want.rank, want.last,
                                 " got col %0d rank %0d final %0b",
                                 o_column_index, o_rank, o_final_result);
                end
            end
        end
    end

    // Element transfer, with an optional random gap before it
    task automatic send_element(logic signed [31:0] value, logic last);
        int gap;
        gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_sample_value <= value;
        i_row_end      <= last;
        do @(posedge i_clk); while (o_in_stall);
        select_update(value, last);
    endtask

    // Drop valid, then wait until every expected pick has arrived
    task automatic quiesce();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_picks.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [rtk_pkg::CFG_IDX_BITS-1:0] idx, logic [4:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == rtk_pkg::REG_K_USED) sel_k = val;
        else sel_smallest = val[0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mix of extremes, small values (ties) and full-range values
    function automatic logic signed [31:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2, 3:    return $signed($urandom_range(0, 4)) - 2;
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic send_row(int len);
        for (int i = 0; i < len; i++)
            send_element(rand_sample(), i == len - 1);
    endtask

    // Reset defaults, zero and large k, short rows, mid-row changes
    task automatic test_directed();
        send_element(32'sh7fff_ffff, 1'b0);
        send_element(32'sh8000_0000, 1'b0);
        send_element(0, 1'b0);
        send_element(-1, 1'b0);
        send_element(32'sh7fff_ffff, 1'b0);
        send_element(1, 1'b0);
        send_element(-1, 1'b0);
        send_element(32'sh5555_aaaa, 1'b1);
        quiesce();
        // zero k keeps one, smallest first
        cfg_write(rtk_pkg::REG_K_USED, 5'd0);
        cfg_write(rtk_pkg::REG_SMALLEST_FIRST, 5'd1);
        send_element(5, 1'b0);
        send_element(-3, 1'b0);
        send_element(-3, 1'b1);
        quiesce();
        // k above the maximum, short row
        cfg_write(rtk_pkg::REG_K_USED, 5'd31);
        send_element(32'sh8000_0000, 1'b0);
        send_element(32'sh7fff_ffff, 1'b1);
        quiesce();
        // k of 3, largest first, entries dropped
        cfg_write(rtk_pkg::REG_K_USED, 5'd3);
        cfg_write(rtk_pkg::REG_SMALLEST_FIRST, 5'd0);
        send_element(2, 1'b0);
        send_element(9, 1'b0);
        send_element(2, 1'b0);
        send_element(9, 1'b0);
        send_element(4, 1'b1);
        quiesce();
        // k lowered mid-row
        cfg_write(rtk_pkg::REG_K_USED, 5'd8);
        send_element(10, 1'b0);
        send_element(30, 1'b0);
        send_element(20, 1'b0);
        quiesce();
        cfg_write(rtk_pkg::REG_K_USED, 5'd2);
        send_element(25, 1'b1);
        quiesce();
        // order toggled mid-row
        cfg_write(rtk_pkg::REG_K_USED, 5'd16);
        send_element(-7, 1'b0);
        send_element(7, 1'b0);
        quiesce();
        cfg_write(rtk_pkg::REG_SMALLEST_FIRST, 5'd1);
        send_element(0, 1'b0);
        send_element(-9, 1'b1);
        quiesce();
    endtask

    // Receiver holds off while rows keep coming, so the input stalls
    task automatic test_backpressure();
        idle_on = 1'b0;
        cfg_write(rtk_pkg::REG_K_USED, 5'd4);
        @(negedge i_clk);
        long_hold = 100;
        for (int r = 0; r < 3; r++)
            send_row(4);
        quiesce();
        idle_on = 1'b1;
    endtask

    // Random rows with configuration changes between them
    task automatic test_random(int item_goal);
        int sent;
        int len;
        sent = 0;
        while (sent < item_goal) begin
            if ($urandom_range(0, 2) == 0) begin
                quiesce();
                case ($urandom_range(0, 4))
                    0:       cfg_write(rtk_pkg::REG_K_USED, 5'd0);
                    1:       cfg_write(rtk_pkg::REG_K_USED, 5'd16);
                    2:       cfg_write(rtk_pkg::REG_K_USED, 5'($urandom_range(17, 31)));
                    default: cfg_write(rtk_pkg::REG_K_USED, 5'($urandom_range(1, 16)));
                endcase
                cfg_write(rtk_pkg::REG_SMALLEST_FIRST, 5'($urandom_range(0, 1)));
            end
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 30) : $urandom_range(1, 12);
            send_row(len);
            sent += len;
        end
        quiesce();
    endtask

    // Back-to-back rows with no idling on either side
    task automatic test_full_rate();
        idle_on = 1'b0;
        cfg_write(rtk_pkg::REG_K_USED, 5'd5);
        for (int r = 0; r < 5; r++)
            send_row($urandom_range(1, 9));
        quiesce();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random(50);
        test_full_rate();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending_picks.size() == 0)
            $display("row_top_k_index_select: match");
        else
            $display("row_top_k_index_select: mismatch");
        $finish;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("row_top_k_index_select: mismatch");
        $finish;
    end

endmodule
